// File: rtl/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// Request codes, controller/datapath command and status types, glyph ROM.
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam int unsigned GlyphColumns = 6;

  typedef enum logic [2:0] {
    REQ_CLEAR = 3'd0,
    REQ_PIXEL = 3'd1,
    REQ_GLYPH = 3'd2,
    REQ_FILL  = 3'd3,
    REQ_FLUSH = 3'd4,
    REQ_MARK  = 3'd5
  } mpf_req_e;

  typedef struct packed {
    logic load;
    logic clear_all;
    logic mark_all;
    logic rd;
    logic wr;
    logic fl_start;
    logic fl_next;
    logic fl_done;
    logic none;
  } mpf_cmd_t;

  typedef struct packed {
    logic hit;
    logic row_last;
    logic page_last;
    logic word_last;
    logic any_dirty;
  } mpf_sts_t;

  // Glyph columns 0..5 packed left to right (column 0 in the top byte).
  function automatic logic [47:0] mpf_font(input logic [6:0] idx);
    logic [47:0] r;
    case (idx)
      7'd1:  r = 48'h00005F000000;
      7'd2:  r = 48'h000700070000;
      7'd3:  r = 48'h147F147F1400;
      7'd4:  r = 48'h242A7F2A1200;
      7'd5:  r = 48'h231308646200;
      7'd6:  r = 48'h364955225000;
      7'd7:  r = 48'h000503000000;
      7'd8:  r = 48'h001C22410000;
      7'd9:  r = 48'h0041221C0000;
      7'd10: r = 48'h082A1C2A0800;
      7'd11: r = 48'h08083E080800;
      7'd12: r = 48'h005030000000;
      7'd13: r = 48'h080808080800;
      7'd14: r = 48'h006060000000;
      7'd15: r = 48'h201008040200;
      7'd16: r = 48'h3E5149453E00;
      7'd17: r = 48'h00427F400000;
      7'd18: r = 48'h426151494600;
      7'd19: r = 48'h2141454B3100;
      7'd20: r = 48'h1814127F1000;
      7'd21: r = 48'h274545453900;
      7'd22: r = 48'h3C4A49493000;
      7'd23: r = 48'h017109050300;
      7'd24: r = 48'h364949493600;
      7'd25: r = 48'h064949291E00;
      7'd26: r = 48'h003636000000;
      7'd27: r = 48'h005636000000;
      7'd28: r = 48'h000814224100;
      7'd29: r = 48'h141414141400;
      7'd30: r = 48'h412214080000;
      7'd31: r = 48'h020151090600;
      7'd32: r = 48'h324979413E00;
      7'd33: r = 48'h7E1111117E00;
      7'd34: r = 48'h7F4949493600;
      7'd35: r = 48'h3E4141412200;
      7'd36: r = 48'h7F414141221C;
      7'd37: r = 48'h7F4949494100;
      7'd38: r = 48'h7F0909010100;
      7'd39: r = 48'h3E4141513200;
      7'd40: r = 48'h7F0808087F00;
      7'd41: r = 48'h00417F410000;
      7'd42: r = 48'h2040413F0100;
      7'd43: r = 48'h7F0814224100;
      7'd44: r = 48'h7F4040404000;
      7'd45: r = 48'h7F0204027F00;
      7'd46: r = 48'h7F0408107F00;
      7'd47: r = 48'h3E4141413E00;
      7'd48: r = 48'h7F0909090600;
      7'd49: r = 48'h3E4151215E00;
      7'd50: r = 48'h7F0919294600;
      7'd51: r = 48'h464949493100;
      7'd52: r = 48'h01017F010100;
      7'd53: r = 48'h3F4040403F00;
      7'd54: r = 48'h1F2040201F00;
      7'd55: r = 48'h7F2018207F00;
      7'd56: r = 48'h631408146300;
      7'd57: r = 48'h030478040300;
      7'd58: r = 48'h615149454300;
      7'd59: r = 48'h00007F414100;
      7'd60: r = 48'h020408102000;
      7'd61: r = 48'h41417F000000;
      7'd62: r = 48'h040201020400;
      7'd63: r = 48'h404040404000;
      7'd64: r = 48'h000102040000;
      7'd65: r = 48'h205454547800;
      7'd66: r = 48'h7F4844443800;
      7'd67: r = 48'h384444442000;
      7'd68: r = 48'h384444487F00;
      7'd69: r = 48'h385454541800;
      7'd70: r = 48'h087E09010200;
      7'd71: r = 48'h081454543C00;
      7'd72: r = 48'h7F0804047800;
      7'd73: r = 48'h00447D400000;
      7'd74: r = 48'h2040443D0000;
      7'd75: r = 48'h007F10284400;
      7'd76: r = 48'h00417F400000;
      7'd77: r = 48'h7C0418047800;
      7'd78: r = 48'h7C0804047800;
      7'd79: r = 48'h384444443800;
      7'd80: r = 48'h7C1414140800;
      7'd81: r = 48'h081414187C00;
      7'd82: r = 48'h7C0804040800;
      7'd83: r = 48'h485454542000;
      7'd84: r = 48'h043F44402000;
      7'd85: r = 48'h3C4040207C00;
      7'd86: r = 48'h1C2040201C00;
      7'd87: r = 48'h3C4030403C00;
      7'd88: r = 48'h442810284400;
      7'd89: r = 48'h0C5050503C00;
      7'd90: r = 48'h446454544C00;
      7'd91: r = 48'h000836410000;
      7'd92: r = 48'h00007F000000;
      7'd93: r = 48'h004136080000;
      7'd94: r = 48'h08082A1C0800;
      default: r = 48'h000000000000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/mpf_ctrl.sv
// ----------------------------------------------------------------------------
// mpf_ctrl
// Request sequencer: decodes requests and steps the datapath through
// read-modify-write rows and flush words.
// ----------------------------------------------------------------------------
module mpf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        req_type_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mpf_pkg::mpf_sts_t sts_i,
  output mpf_pkg::mpf_cmd_t cmd_o
);
  import mpf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_WR   = 6'b000100,
    S_FRD  = 6'b001000,
    S_FOUT = 6'b010000,
    S_NONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (req_type_i)
            REQ_CLEAR: cmd_o.clear_all = 1'b1;
            REQ_MARK:  cmd_o.mark_all = 1'b1;
            REQ_PIXEL, REQ_GLYPH, REQ_FILL: begin
              cmd_o.load = 1'b1;
              if (sts_i.hit) state_d = S_RD;
            end
            REQ_FLUSH: begin
              if (sts_i.any_dirty) begin
                cmd_o.fl_start = 1'b1;
                state_d = S_FRD;
              end else begin
                state_d = S_NONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = (sts_i.row_last && sts_i.page_last) ? S_IDLE : S_RD;
      end
      S_FRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_FOUT;
      end
      S_FOUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.word_last) begin
            cmd_o.fl_done = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.fl_next = 1'b1;
            state_d = S_FRD;
          end
        end
      end
      S_NONE: begin
        out_valid_o = 1'b1;
        cmd_o.none  = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/mpf_dp.sv
// ----------------------------------------------------------------------------
// mpf_dp
// Frame store rows of 8 column bytes with per-row valid bits, dirty mask,
// request registers, row/page walk and row merge logic.
// ----------------------------------------------------------------------------
module mpf_dp #(
  parameter int unsigned DISPLAY_COLUMNS = 128,
  parameter int unsigned DISPLAY_PAGES   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpf_pkg::mpf_cmd_t cmd_i,
  output mpf_pkg::mpf_sts_t sts_o,
  input  logic [2:0]        req_type_i,
  input  logic [7:0]        column_i,
  input  logic [7:0]        row_or_page_i,
  input  logic              pixel_on_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        fill_width_i,
  input  logic [7:0]        fill_height_i,
  input  logic [7:0]        fill_byte_i,
  output logic [2:0]        page_index_o,
  output logic [6:0]        column_base_o,
  output logic [63:0]       pixel_bytes_o,
  output logic              nothing_dirty_o,
  output logic              last_o
);
  import mpf_pkg::*;

  localparam int unsigned Words      = (DISPLAY_COLUMNS + 7) / 8;
  localparam int unsigned WW         = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PW         = (DISPLAY_PAGES > 1) ? $clog2(DISPLAY_PAGES) : 1;
  localparam int unsigned AW         = PW + WW;
  localparam int unsigned Depth      = 1 << AW;
  localparam int unsigned FlushWords = (Words > 16) ? 16 : Words;
  localparam logic [9:0]  ColLim     = 10'(DISPLAY_COLUMNS);
  localparam logic [9:0]  RowLim     = 10'(DISPLAY_PAGES * 8);
  localparam logic [9:0]  PageLim    = 10'(DISPLAY_PAGES);
  localparam logic [9:0]  GlyphSpan  = 10'(GlyphColumns - 1);

  logic [63:0]              mem_q [Depth];
  logic [63:0]              rd_q;
  logic                     rv_q;
  logic [Depth-1:0]         vld_q;
  logic [DISPLAY_PAGES-1:0] dirty_q;

  mpf_req_e    req_q;
  logic [9:0]  col_q, ce_q;
  logic [2:0]  bit_q;
  logic        on_q;
  logic [47:0] glyph_q;
  logic [7:0]  fb_q;
  logic [PW-1:0] p_q, p_end_q;
  logic [WW-1:0] w_q, w_start_q, w_end_q;

  logic [AW-1:0] addr;
  assign addr = {p_q, w_q};

  // request decode
  logic [9:0] col10, rp10, g_sum, g_end, f_sum, f_end, ps_sum, p_lim;
  logic       pix_hit, gly_hit, fill_pages, fill_hit;
  logic [6:0] font_idx;
  logic [DISPLAY_PAGES-1:0] mark;
  logic [PW-1:0] lowest;

  always_comb begin
    col10      = {2'b00, column_i};
    rp10       = {2'b00, row_or_page_i};
    g_sum      = col10 + GlyphSpan;
    g_end      = (g_sum > ColLim - 10'd1) ? ColLim - 10'd1 : g_sum;
    f_sum      = col10 + {2'b00, fill_width_i};
    f_end      = ((f_sum > ColLim) ? ColLim : f_sum) - 10'd1;
    ps_sum     = rp10 + {2'b00, fill_height_i};
    p_lim      = ((ps_sum > PageLim) ? PageLim : ps_sum) - 10'd1;
    pix_hit    = (col10 < ColLim) && (rp10 < RowLim);
    gly_hit    = (col10 < ColLim) && (rp10 < PageLim);
    fill_pages = (rp10 < PageLim) && (fill_height_i != 8'd0);
    fill_hit   = fill_pages && (col10 < ColLim) && (fill_width_i != 8'd0);
    font_idx   = (char_code_i >= 8'd32 && char_code_i <= 8'd127) ?
                 7'(char_code_i - 8'd32) : 7'd0;
    for (int i = 0; i < DISPLAY_PAGES; i++) begin
      case (req_type_i)
        REQ_PIXEL: mark[i] = pix_hit && (rp10[9:3] == 7'(i));
        REQ_GLYPH: mark[i] = gly_hit && (rp10 == 10'(i));
        REQ_FILL:  mark[i] = fill_pages && (10'(i) >= rp10) && (10'(i) <= p_lim);
        default:   mark[i] = 1'b0;
      endcase
    end
    lowest = '0;
    for (int i = DISPLAY_PAGES - 1; i >= 0; i--) begin
      if (dirty_q[i]) lowest = PW'(i);
    end
  end

  always_comb begin
    sts_o.row_last  = (w_q == w_end_q);
    sts_o.page_last = (p_q == p_end_q);
    sts_o.word_last = (w_q == WW'(FlushWords - 1));
    sts_o.any_dirty = |dirty_q;
    case (req_type_i)
      REQ_PIXEL: sts_o.hit = pix_hit;
      REQ_GLYPH: sts_o.hit = gly_hit;
      REQ_FILL:  sts_o.hit = fill_hit;
      default:   sts_o.hit = 1'b0;
    endcase
  end

  // row merge
  logic [63:0] wdata;
  always_comb begin
    logic [9:0] c;
    logic [9:0] off;
    logic [7:0] old;
    logic [2:0] sh;
    for (int b = 0; b < 8; b++) begin
      c   = 10'({w_q, 3'(b)});
      off = c - col_q;
      sh  = 3'(GlyphSpan - off);
      old = rv_q ? rd_q[8*b +: 8] : 8'h00;
      wdata[8*b +: 8] = old;
      if (c >= col_q && c <= ce_q) begin
        case (req_q)
          REQ_PIXEL: wdata[8*b +: 8] = on_q ? (old | (8'h01 << bit_q))
                                             : (old & ~(8'h01 << bit_q));
          REQ_GLYPH: wdata[8*b +: 8] = glyph_q[8*sh +: 8];
          default:   wdata[8*b +: 8] = fb_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem_q[addr] <= wdata;
    if (cmd_i.rd) rd_q <= mem_q[addr];
    if (cmd_i.load) begin
      req_q   <= mpf_req_e'(req_type_i);
      col_q   <= col10;
      bit_q   <= row_or_page_i[2:0];
      on_q    <= pixel_on_i;
      glyph_q <= mpf_font(font_idx);
      fb_q    <= fill_byte_i;
      case (req_type_i)
        REQ_PIXEL: ce_q <= col10;
        REQ_GLYPH: ce_q <= g_end;
        default:   ce_q <= f_end;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rv_q      <= 1'b0;
      dirty_q   <= '0;
      p_q       <= '0;
      p_end_q   <= '0;
      w_q       <= '0;
      w_start_q <= '0;
      w_end_q   <= '0;
    end else begin
      if (cmd_i.rd) rv_q <= vld_q[addr];
      if (cmd_i.clear_all) begin
        vld_q   <= '0;
        dirty_q <= '1;
      end
      if (cmd_i.mark_all) dirty_q <= '1;
      if (cmd_i.load) begin
        dirty_q   <= dirty_q | mark;
        w_q       <= WW'(column_i >> 3);
        w_start_q <= WW'(column_i >> 3);
        case (req_type_i)
          REQ_PIXEL: begin
            p_q     <= PW'(row_or_page_i >> 3);
            p_end_q <= PW'(row_or_page_i >> 3);
            w_end_q <= WW'(column_i >> 3);
          end
          REQ_GLYPH: begin
            p_q     <= PW'(row_or_page_i);
            p_end_q <= PW'(row_or_page_i);
            w_end_q <= WW'(g_end >> 3);
          end
          default: begin
            p_q     <= PW'(row_or_page_i);
            p_end_q <= PW'(p_lim);
            w_end_q <= WW'(f_end >> 3);
          end
        endcase
      end
      if (cmd_i.wr) begin
        vld_q[addr] <= 1'b1;
        if (w_q == w_end_q) begin
          w_q <= w_start_q;
          p_q <= p_q + PW'(1);
        end else begin
          w_q <= w_q + WW'(1);
        end
      end
      if (cmd_i.fl_start) begin
        p_q <= lowest;
        w_q <= '0;
      end
      if (cmd_i.fl_next) w_q <= w_q + WW'(1);
      if (cmd_i.fl_done) dirty_q[p_q] <= 1'b0;
    end
  end

  assign page_index_o    = cmd_i.none ? 3'd0 : 3'(p_q);
  assign column_base_o   = cmd_i.none ? 7'd0 : 7'({w_q, 3'b000});
  assign pixel_bytes_o   = (cmd_i.none || !rv_q) ? 64'd0 : rd_q;
  assign nothing_dirty_o = cmd_i.none;
  assign last_o          = cmd_i.none || sts_o.word_last;

endmodule

// File: rtl/monochrome_page_framebuffer.sv
// ----------------------------------------------------------------------------
// monochrome_page_framebuffer
// Page-organized monochrome frame store with dirty-page tracking and flush.
// ----------------------------------------------------------------------------
// Requests arrive on the in_valid_i/in_ready_o channel, one transfer per
// request; flush results leave on out_valid_o/out_ready_i, one transfer per
// 8-byte word. The store is kept as rows of 8 column bytes in a single-port
// memory, each row with a valid bit; an invalid row reads as zero, so reset
// and the clear request empty the store by clearing the valid bits.
// Clear and mark-all complete on acceptance. Pixel, glyph and fill load the
// request, then do a read-modify-write per touched row (a read state, then a
// write state): pixel one row, glyph one or two, fill up to pages * rows. A
// flush reads each word and offers it before reading the next, 16 words for
// a 128-column page, as the memory has one read port; a flush with nothing
// dirty gives a single result.
// in_ready_o is high only while no request is in progress. When the receiver
// stalls, the current result holds on the outputs and the walk waits.
// Reset empties the store and clears the dirty mask.
// ----------------------------------------------------------------------------
module monochrome_page_framebuffer #(
  parameter int unsigned DISPLAY_COLUMNS = 128,
  parameter int unsigned DISPLAY_PAGES   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  row_or_page_i,
  input  logic        pixel_on_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  fill_width_i,
  input  logic [7:0]  fill_height_i,
  input  logic [7:0]  fill_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  page_index_o,
  output logic [6:0]  column_base_o,
  output logic [63:0] pixel_bytes_o,
  output logic        nothing_dirty_o,
  output logic        last_o
);
  import mpf_pkg::*;

  mpf_cmd_t cmd;
  mpf_sts_t sts;

  mpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mpf_dp #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_PAGES   (DISPLAY_PAGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .column_i        (column_i),
    .row_or_page_i   (row_or_page_i),
    .pixel_on_i      (pixel_on_i),
    .char_code_i     (char_code_i),
    .fill_width_i    (fill_width_i),
    .fill_height_i   (fill_height_i),
    .fill_byte_i     (fill_byte_i),
    .page_index_o    (page_index_o),
    .column_base_o   (column_base_o),
    .pixel_bytes_o   (pixel_bytes_o),
    .nothing_dirty_o (nothing_dirty_o),
    .last_o          (last_o)
  );

endmodule

// File: dv/mpf_checker.sv
// ----------------------------------------------------------------------------
// mpf_checker
// Watches both channels of the frame store, keeps its own copy of the store
// and dirty mask, predicts every flush word and compares field by field.
// ----------------------------------------------------------------------------
module mpf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  row_or_page_i,
  input  logic        pixel_on_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  fill_width_i,
  input  logic [7:0]  fill_height_i,
  input  logic [7:0]  fill_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  page_index_i,
  input  logic [6:0]  column_base_i,
  input  logic [63:0] pixel_bytes_i,
  input  logic        nothing_dirty_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          words_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpf_pkg::*;

  localparam int Cols  = 128;
  localparam int Pages = 8;

  typedef struct packed {
    logic [2:0]  page;
    logic [6:0]  base;
    logic [63:0] bytes;
    logic        none;
    logic        last;
  } flush_word_t;

  logic [7:0]  shadow_store [Pages*Cols];
  logic [7:0]  shadow_dirty;
  flush_word_t expected_words [$];

  // Font table rebuilt from the standard 6x8 glyph set, column 0 first.
  logic [7:0] glyph_rom [96][6];

  initial begin
    logic [47:0] rows [96];
    rows = '{
      48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
      48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
      48'h001C22410000, 48'h0041221C0000, 48'h082A1C2A0800, 48'h08083E080800,
      48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
      48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
      48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
      48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
      48'h000814224100, 48'h141414141400, 48'h412214080000, 48'h020151090600,
      48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
      48'h7F414141221C, 48'h7F4949494100, 48'h7F0909010100, 48'h3E4141513200,
      48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
      48'h7F4040404000, 48'h7F0204027F00, 48'h7F0408107F00, 48'h3E4141413E00,
      48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
      48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h7F2018207F00,
      48'h631408146300, 48'h030478040300, 48'h615149454300, 48'h00007F414100,
      48'h020408102000, 48'h41417F000000, 48'h040201020400, 48'h404040404000,
      48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
      48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h081454543C00,
      48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h007F10284400,
      48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
      48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
      48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
      48'h442810284400, 48'h0C5050503C00, 48'h446454544C00, 48'h000836410000,
      48'h00007F000000, 48'h004136080000, 48'h08082A1C0800, 48'h000000000000};
    for (int g = 0; g < 96; g++)
      for (int c = 0; c < 6; c++)
        glyph_rom[g][c] = rows[g][47-8*c -: 8];
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic apply_request(input logic [2:0] req, input logic [7:0] col,
                               input logic [7:0] rp, input logic on,
                               input logic [7:0] code, input logic [7:0] fw,
                               input logic [7:0] fh, input logic [7:0] fb);
    int pg;
    int cc;
    int g;
    flush_word_t w;
    case (req)
      REQ_CLEAR: begin
        foreach (shadow_store[k]) shadow_store[k] = '0;
        shadow_dirty = 8'hFF;
      end
      REQ_PIXEL: begin
        if (col < Cols && rp < Pages*8) begin
          pg = rp >> 3;
          shadow_store[pg*Cols+col][rp[2:0]] = on;
          shadow_dirty[pg] = 1'b1;
        end
      end
      REQ_GLYPH: begin
        if (col < Cols && rp < Pages) begin
          g = (code < 32 || code > 127) ? 0 : code - 32;
          for (int i = 0; i < 6 && col + i < Cols; i++)
            shadow_store[rp*Cols+col+i] = glyph_rom[g][i];
          shadow_dirty[rp] = 1'b1;
        end
      end
      REQ_FILL: begin
        for (pg = rp; pg < rp + fh && pg < Pages; pg++) begin
          for (int i = 0; i < fw && col + i < Cols; i++)
            shadow_store[pg*Cols+col+i] = fb;
          shadow_dirty[pg] = 1'b1;
        end
      end
      REQ_FLUSH: begin
        pg = -1;
        for (int p = Pages - 1; p >= 0; p--) if (shadow_dirty[p]) pg = p;
        if (pg < 0) begin
          expected_words.push_back('{page: '0, base: '0, bytes: '0, none: 1'b1,
                                     last: 1'b1});
        end else begin
          for (int wi = 0; wi < 16; wi++) begin
            w.page = pg[2:0];
            w.base = 7'(wi*8);
            w.none = 1'b0;
            w.last = (wi == 15);
            for (int b = 0; b < 8; b++) begin
              cc = wi*8 + b;
              w.bytes[8*b +: 8] = shadow_store[pg*Cols+cc];
            end
            expected_words.push_back(w);
          end
          shadow_dirty[pg] = 1'b0;
        end
      end
      REQ_MARK: shadow_dirty = 8'hFF;
      default: ;
    endcase
  endtask

  initial begin
    fail_count_o = 0;
    words_seen_o = 0;
    pending_o    = 0;
    shadow_dirty = '0;
    foreach (shadow_store[k]) shadow_store[k] = '0;
  end

  always @(posedge clk_i) begin
    flush_word_t w;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        words_seen_o++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", pixel_bytes_i, '0);
        end else begin
          w = expected_words.pop_front();
          if (page_index_i !== w.page)
            report_mismatch("page_index", 64'(page_index_i), 64'(w.page));
          if (column_base_i !== w.base)
            report_mismatch("column_base", 64'(column_base_i), 64'(w.base));
          if (pixel_bytes_i !== w.bytes)
            report_mismatch("pixel_bytes", pixel_bytes_i, w.bytes);
          if (nothing_dirty_i !== w.none)
            report_mismatch("nothing_dirty", 64'(nothing_dirty_i), 64'(w.none));
          if (last_i !== w.last) report_mismatch("last", 64'(last_i), 64'(w.last));
        end
      end
      if (in_valid_i && in_ready_i)
        apply_request(req_type_i, column_i, row_or_page_i, pixel_on_i, char_code_i,
                      fill_width_i, fill_height_i, fill_byte_i);
      pending_o = expected_words.size();
    end
  end

endmodule

// File: dv/tb_monochrome_page_framebuffer.sv
// ----------------------------------------------------------------------------
// tb_monochrome_page_framebuffer
// Drives directed and random draw, fill, clear, mark and flush requests into
// the frame store under varying back-pressure; a checker predicts all flush words.
// ----------------------------------------------------------------------------
module tb_monochrome_page_framebuffer;
  timeunit 1ns;
  timeprecision 1ps;
  import mpf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [7:0]  column_i = '0;
  logic [7:0]  row_or_page_i = '0;
  logic        pixel_on_i = 1'b0;
  logic [7:0]  char_code_i = '0;
  logic [7:0]  fill_width_i = '0;
  logic [7:0]  fill_height_i = '0;
  logic [7:0]  fill_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  page_index_o;
  logic [6:0]  column_base_o;
  logic [63:0] pixel_bytes_o;
  logic        nothing_dirty_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          words_seen;

  int send_idle_pct = 29;
  int recv_idle_pct = 81;
  bit hold_recv = 1'b0;
  int req_count = 0;

  always #5 clk_i = ~clk_i;

  monochrome_page_framebuffer u_top (.*);

  mpf_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .column_i,
    .row_or_page_i, .pixel_on_i, .char_code_i, .fill_width_i, .fill_height_i,
    .fill_byte_i, .out_valid_i(out_valid_o), .out_ready_i, .page_index_i(page_index_o),
    .column_base_i(column_base_o), .pixel_bytes_i(pixel_bytes_o),
    .nothing_dirty_i(nothing_dirty_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending), .words_seen_o(words_seen)
  );

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_req(input logic [2:0] req, input logic [7:0] col,
                          input logic [7:0] rp, input logic on, input logic [7:0] code,
                          input logic [7:0] fw, input logic [7:0] fh,
                          input logic [7:0] fb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    column_i      <= col;
    row_or_page_i <= rp;
    pixel_on_i    <= on;
    char_code_i   <= code;
    fill_width_i  <= fw;
    fill_height_i <= fh;
    fill_byte_i   <= fb;
    do @(posedge clk_i); while (!in_ready_o);
    req_count++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic send_random_req();
    logic [2:0] req;
    logic [7:0] col;
    logic [7:0] rp;
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) req = 3'($urandom_range(7, 6));
    else if (pick < 6) req = REQ_CLEAR;
    else if (pick < 9) req = REQ_MARK;
    else if (pick < 30) req = REQ_FLUSH;
    else req = 3'($urandom_range(3, 1));
    col = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(127));
    if (req == REQ_PIXEL)
      rp = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(63));
    else
      rp = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    send_req(req, col, rp, 1'($urandom), 8'($urandom),
             ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20)),
             ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
             8'($urandom));
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: flush of empty store, drawing extremes, clipping, all codes
    send_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_PIXEL, 0, 0, 1, 0, 0, 0, 0);
    send_req(REQ_PIXEL, 127, 63, 1, 0, 0, 0, 0);
    send_req(REQ_PIXEL, 128, 5, 1, 0, 0, 0, 0);
    send_req(REQ_PIXEL, 5, 64, 1, 0, 0, 0, 0);
    send_req(REQ_PIXEL, 127, 63, 0, 0, 0, 0, 0);
    send_req(REQ_GLYPH, 10, 1, 0, 8'h41, 0, 0, 0);
    send_req(REQ_GLYPH, 20, 1, 0, 8'h7F, 0, 0, 0);
    send_req(REQ_GLYPH, 30, 1, 0, 8'h05, 0, 0, 0);
    send_req(REQ_GLYPH, 40, 1, 0, 8'hFF, 0, 0, 0);
    send_req(REQ_GLYPH, 124, 2, 0, 8'h44, 0, 0, 0);
    send_req(REQ_GLYPH, 200, 2, 0, 8'h44, 0, 0, 0);
    send_req(REQ_GLYPH, 0, 8, 0, 8'h44, 0, 0, 0);
    send_req(REQ_FILL, 120, 6, 0, 0, 255, 255, 8'hA5);
    send_req(REQ_FILL, 200, 3, 0, 0, 4, 1, 8'hFF);
    send_req(REQ_FILL, 3, 4, 0, 0, 0, 1, 8'hFF);
    send_req(REQ_FILL, 0, 0, 0, 0, 128, 0, 8'h5A);
    send_req(3'd6, 0, 0, 0, 0, 0, 0, 0);
    send_req(3'd7, 0, 0, 0, 0, 0, 0, 0);
    repeat (8) send_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_MARK, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
    repeat (60) send_random_req();
    // long receiver hold-off while requests keep coming
    hold_recv <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_recv <= 1'b0;
      end
      begin
        send_req(REQ_MARK, 0, 0, 0, 0, 0, 0, 0);
        repeat (2) send_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
        repeat (3) send_random_req();
      end
    join
    stop_sending();
    wait_drained();
    send_idle_pct = 81;
    recv_idle_pct = 29;
    repeat (60) send_random_req();
    stop_sending();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (60) send_random_req();
    stop_sending();
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests, %0d flush words checked, with sender and receiver stalls.",
             req_count, words_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
